FILE: hw/rtl/i2cmt_pkg.sv
// ----------------------------------------------------------------------------
// i2cmt_pkg
// Shared types and constants for the I2C master memory transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmt_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_EEPROM_DEV = 2'd0;
   localparam logic [1:0] CSR_CLOCK_DEV  = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT = 2'd2;

   // configuration reset values
   localparam logic [7:0]  EEPROM_DEV_RESET = 8'hA0;
   localparam logic [7:0]  CLOCK_DEV_RESET  = 8'hD0;
   localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

   // transfer kinds carried in the mode field
   localparam logic [2:0] MODE_EEPROM_RD = 3'd1;
   localparam logic [2:0] MODE_EEPROM_WR = 3'd2;
   localparam logic [2:0] MODE_CLOCK_RD  = 3'd3;
   localparam logic [2:0] MODE_CLOCK_WR  = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_TX_SET,
      PH_TX_LO1,
      PH_TX_HI,
      PH_TX_LO2,
      PH_TX_REL,
      PH_POLL,
      PH_ACK_HI,
      PH_ACK_LO,
      PH_RX_LO,
      PH_RX_HI,
      PH_MACK_LO,
      PH_MACK_HI,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      SG_START1,
      SG_DEV,
      SG_AHI,
      SG_ALO,
      SG_START2,
      SG_DEVR,
      SG_DATA,
      SG_STOP
   } stage_type;

   typedef struct packed {
      logic [7:0]  eeprom_dev;
      logic [7:0]  clock_dev;
      logic [15:0] poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] mem_address;
      logic [7:0]  byte_count;
      logic [7:0]  wr_data;
      logic        sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_level;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       wr_taken;
      logic       busy_res;
      logic       done_res;
      logic       ack_error;
   } rsp_type;

endpackage

FILE: hw/rtl/i2cmt_seq.sv
// ----------------------------------------------------------------------------
// i2cmt_seq
// Bus sequencer: one tick per advance, holds the transfer state and produces
// the line levels and status of that tick.
// ----------------------------------------------------------------------------
module i2cmt_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  i2cmt_pkg::cfg_type cfg,
   input  i2cmt_pkg::req_type item,
   output i2cmt_pkg::rsp_type result
);
   import i2cmt_pkg::*;

   typedef struct packed {
      stage_type  stage;
      phase_type  phase;
      logic       idle;
      logic       bit_load;
      logic [2:0] bit_val;
      logic [7:0] left;
      logic       shift_clr;
   } ent_type;

   phase_type   phase_ff, phase_in, c_phase;
   stage_type   stage_ff, stage_in, c_stage;
   logic [2:0]  bit_ff, bit_in, c_bit;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  left_ff, left_in, c_left;
   logic [15:0] addr_ff, addr_in, c_addr;
   logic        rd_ff, rd_in, c_rd;
   logic        ee_ff, ee_in, c_ee;
   logic [15:0] poll_ff, poll_in, c_poll;
   logic        err_ff, err_in, c_err;
   logic [15:0] poll_inc;
   logic [7:0]  dev;
   logic        cur_bit;
   logic        starting;
   ent_type     nxt;

   function automatic ent_type enter_fn(input stage_type s, input logic [7:0] left,
                                        input logic rd);
      ent_type e;
      e = '{stage: s, phase: PH_TX_SET, idle: 1'b0, bit_load: 1'b0, bit_val: 3'd0,
            left: left, shift_clr: 1'b0};
      case (s)
         SG_START1, SG_START2: begin
            e.phase    = PH_START;
            e.bit_load = 1'b1;
         end
         SG_DATA: begin
            if (left == 8'd0) begin
               e.stage    = SG_STOP;
               e.phase    = PH_STOP;
               e.bit_load = 1'b1;
            end else begin
               e.left = left - 8'd1;
               if (rd) begin
                  e.phase     = PH_RX_LO;
                  e.bit_load  = 1'b1;
                  e.bit_val   = 3'd7;
                  e.shift_clr = 1'b1;
               end
            end
         end
         SG_STOP: begin
            e.phase    = PH_STOP;
            e.bit_load = 1'b1;
         end
         default: e.phase = PH_TX_SET;
      endcase
      return e;
   endfunction

   function automatic ent_type next_fn(input stage_type s, input logic ee, input logic rd,
                                       input logic [7:0] left);
      ent_type e;
      e = '{stage: s, phase: PH_IDLE, idle: 1'b1, bit_load: 1'b0, bit_val: 3'd0,
            left: left, shift_clr: 1'b0};
      case (s)
         SG_START1: e = enter_fn(SG_DEV, left, rd);
         SG_DEV:    e = enter_fn(ee ? SG_AHI : SG_ALO, left, rd);
         SG_AHI:    e = enter_fn(SG_ALO, left, rd);
         SG_ALO:    e = enter_fn(rd ? SG_START2 : SG_DATA, left, rd);
         SG_START2: e = enter_fn(SG_DEVR, left, rd);
         SG_DEVR:   e = enter_fn(SG_DATA, left, rd);
         SG_DATA:   e = enter_fn(SG_DATA, left, rd);
         default:   e.idle = 1'b1;
      endcase
      return e;
   endfunction

   // a transfer request on an idle tick loads the context and begins the start
   assign starting = (phase_ff == PH_IDLE) && (item.mode >= MODE_EEPROM_RD) &&
                     (item.mode <= MODE_CLOCK_WR);

   always_comb begin
      c_phase = starting ? PH_START : phase_ff;
      c_stage = starting ? SG_START1 : stage_ff;
      c_bit   = starting ? 3'd0 : bit_ff;
      c_left  = starting ? item.byte_count : left_ff;
      c_addr  = starting ? item.mem_address : addr_ff;
      c_rd    = starting ? (item.mode == MODE_EEPROM_RD || item.mode == MODE_CLOCK_RD)
                         : rd_ff;
      c_ee    = starting ? (item.mode == MODE_EEPROM_RD || item.mode == MODE_EEPROM_WR)
                         : ee_ff;
      c_poll  = starting ? 16'd0 : poll_ff;
      c_err   = starting ? 1'b0 : err_ff;
   end

   assign dev      = c_ee ? cfg.eeprom_dev : cfg.clock_dev;
   assign cur_bit  = shift_ff[c_bit];
   assign poll_inc = c_poll + 16'd1;
   assign nxt      = next_fn(c_stage, c_ee, c_rd, c_left);

   // next state
   always_comb begin
      phase_in = c_phase;
      stage_in = c_stage;
      bit_in   = c_bit;
      shift_in = shift_ff;
      left_in  = c_left;
      addr_in  = c_addr;
      rd_in    = c_rd;
      ee_in    = c_ee;
      poll_in  = c_poll;
      err_in   = c_err;
      case (c_phase)
         PH_IDLE: begin
         end
         PH_START: begin
            if (c_bit >= 3'd5) begin
               phase_in = nxt.phase;
               stage_in = nxt.stage;
               left_in  = nxt.left;
               if (nxt.bit_load) bit_in = nxt.bit_val;
               if (nxt.shift_clr) shift_in = 8'd0;
            end else begin
               bit_in = c_bit + 3'd1;
            end
         end
         PH_TX_SET: begin
            case (c_stage)
               SG_DEV:  shift_in = dev;
               SG_AHI:  shift_in = c_addr[15:8];
               SG_ALO:  shift_in = c_addr[7:0];
               SG_DEVR: shift_in = dev | 8'h01;
               default: shift_in = item.wr_data;
            endcase
            bit_in   = 3'd7;
            phase_in = PH_TX_LO1;
         end
         PH_TX_LO1: phase_in = PH_TX_HI;
         PH_TX_HI:  phase_in = PH_TX_LO2;
         PH_TX_LO2: begin
            if (c_bit == 3'd0) begin
               phase_in = PH_TX_REL;
            end else begin
               bit_in   = c_bit - 3'd1;
               phase_in = PH_TX_LO1;
            end
         end
         PH_TX_REL: begin
            poll_in  = 16'd0;
            phase_in = PH_POLL;
         end
         PH_POLL: begin
            if (!item.sda_sample) begin
               phase_in = PH_ACK_HI;
            end else begin
               poll_in = poll_inc;
               // ack timeout skips the acknowledge clock pulse
               if (poll_inc >= cfg.poll_limit) begin
                  err_in   = 1'b1;
                  phase_in = nxt.phase;
                  stage_in = nxt.stage;
                  left_in  = nxt.left;
                  if (nxt.bit_load) bit_in = nxt.bit_val;
                  if (nxt.shift_clr) shift_in = 8'd0;
               end
            end
         end
         PH_ACK_HI: phase_in = PH_ACK_LO;
         PH_ACK_LO, PH_MACK_HI: begin
            phase_in = nxt.phase;
            stage_in = nxt.stage;
            left_in  = nxt.left;
            if (nxt.bit_load) bit_in = nxt.bit_val;
            if (nxt.shift_clr) shift_in = 8'd0;
         end
         PH_RX_LO: phase_in = PH_RX_HI;
         PH_RX_HI: begin
            shift_in = {shift_ff[6:0], item.sda_sample};
            if (c_bit == 3'd0) begin
               phase_in = PH_MACK_LO;
            end else begin
               bit_in   = c_bit - 3'd1;
               phase_in = PH_RX_LO;
            end
         end
         PH_MACK_LO: phase_in = PH_MACK_HI;
         PH_STOP: begin
            if (c_bit >= 3'd5) begin
               phase_in = PH_IDLE;
               stage_in = SG_START1;
            end else begin
               bit_in = c_bit + 3'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            stage_in = SG_START1;
         end
      endcase
   end

   // line levels and status of this tick
   always_comb begin
      result           = '0;
      result.busy_res  = (c_phase != PH_IDLE);
      result.ack_error = err_in;
      case (c_phase)
         PH_START: begin
            result.scl_level = (c_bit == 3'd3) || (c_bit == 3'd4);
            result.sda_drive = (c_bit != 3'd0);
            result.sda_level = (c_bit >= 3'd1) && (c_bit <= 3'd3);
         end
         PH_TX_SET: begin
            result.sda_drive = 1'b1;
            result.wr_taken  = (c_stage != SG_DEV) && (c_stage != SG_AHI) &&
                               (c_stage != SG_ALO) && (c_stage != SG_DEVR);
         end
         PH_TX_LO1, PH_TX_LO2: begin
            result.sda_drive = 1'b1;
            result.sda_level = cur_bit;
         end
         PH_TX_HI: begin
            result.scl_level = 1'b1;
            result.sda_drive = 1'b1;
            result.sda_level = cur_bit;
         end
         PH_ACK_HI: result.scl_level = 1'b1;
         PH_RX_HI: begin
            result.scl_level = 1'b1;
            if (c_bit == 3'd0) begin
               result.rd_valid = 1'b1;
               result.rd_data  = {shift_ff[6:0], item.sda_sample};
            end
         end
         PH_MACK_LO: result.sda_drive = (c_left != 8'd0);
         PH_MACK_HI: begin
            result.scl_level = 1'b1;
            result.sda_drive = (c_left != 8'd0);
         end
         PH_STOP: begin
            result.scl_level = (c_bit == 3'd2) || (c_bit == 3'd3);
            result.sda_drive = (c_bit < 3'd5);
            result.sda_level = (c_bit == 3'd3) || (c_bit == 3'd4);
            result.done_res  = (c_bit >= 3'd5);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stage_ff <= SG_START1;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         left_ff  <= 8'd0;
         addr_ff  <= 16'd0;
         rd_ff    <= 1'b0;
         ee_ff    <= 1'b0;
         poll_ff  <= 16'd0;
         err_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         stage_ff <= stage_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         rd_ff    <= rd_in;
         ee_ff    <= ee_in;
         poll_ff  <= poll_in;
         err_ff   <= err_in;
      end
   end

endmodule

FILE: hw/rtl/i2c_master_memory_transfer.sv
// ----------------------------------------------------------------------------
// i2c_master_memory_transfer
// I2C master for EEPROM and real-time-clock reads and writes, one bus tick
// per input transfer.
// ----------------------------------------------------------------------------
// Output: a tick's result is registered and sits in the output register from the
// cycle after its transfer.
// Throughput: one tick per cycle while rsp_tready is high; a held result
// blocks req_tready, and a new tick is taken in the cycle the held one drains.
// Reset: synchronous, active high; sequencer goes idle, registers return to
// device bytes 0xA0 / 0xD0 and an ack poll limit of 1000.
module i2c_master_memory_transfer (
   input  logic        clock,
   input  logic        reset,
   // input ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // mem_address, byte_count, wr_data, sda_sample, pad
   input  logic [2:0]  req_tuser,  // mode
   // per-tick results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_level, sda_drive, sda_level, rd_data, rd_valid, wr_taken, busy_res,
   // ack_error, pad
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,  // done_res
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import i2cmt_pkg::*;

   cfg_type cfg_ff;
   req_type item;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eeprom_dev <= EEPROM_DEV_RESET;
         cfg_ff.clock_dev  <= CLOCK_DEV_RESET;
         cfg_ff.poll_limit <= POLL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EEPROM_DEV: cfg_ff.eeprom_dev <= csr_data[7:0];
            CSR_CLOCK_DEV:  cfg_ff.clock_dev  <= csr_data[7:0];
            CSR_POLL_LIMIT: cfg_ff.poll_limit <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign item.mode        = req_tuser;
   assign item.mem_address = req_tdata[15:0];
   assign item.byte_count  = req_tdata[23:16];
   assign item.wr_data     = req_tdata[31:24];
   assign item.sda_sample  = req_tdata[32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   i2cmt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .item    (item),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.done_res;
   assign rsp_tdata  = {1'b0, rsp_ff.ack_error, rsp_ff.busy_res, rsp_ff.wr_taken,
                        rsp_ff.rd_valid, rsp_ff.rd_data, rsp_ff.sda_level,
                        rsp_ff.sda_drive, rsp_ff.scl_level};

   // every accepted tick leaves a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted tick left no result");

   // sda is never shown high while released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && !rsp_tdata[1]))
      else $error("sda level set while released");

   // a read byte completes only on an scl high tick of a busy transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11]) |-> (rsp_tdata[0] && rsp_tdata[13]))
      else $error("read byte outside scl high tick");

   // the stop tick belongs to a transfer, shows scl low and releases sda
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[13] && !rsp_tdata[0] && !rsp_tdata[1]))
      else $error("malformed stop tick");

endmodule
